// ===== design/mtg_pkg.sv =====
package mtg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int SHIFT_OFFSET = 397;
    localparam int KEY_DEPTH    = 64;

    localparam int ADDR_W    = 10;
    localparam int KEY_AW    = 6;
    localparam int KEY_CNT_W = 7;

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] WORDS_CNT  = ADDR_W'(STATE_WORDS);
    localparam logic [ADDR_W-1:0] OFFSET_CNT = ADDR_W'(SHIFT_OFFSET);

    localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [31:0] UPPER_BIT    = 32'h8000_0000;
    localparam logic [31:0] LOWER_BITS   = 32'h7fff_ffff;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] MIX1_MULT    = 32'd1664525;
    localparam logic [31:0] MIX2_MULT    = 32'd1566083941;
    localparam logic [31:0] ARRAY_SEED   = 32'd19650218;

    localparam logic [1:0] REQ_SEED = 2'd0;
    localparam logic [1:0] REQ_KEY  = 2'd1;
    localparam logic [1:0] REQ_NEXT = 2'd2;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & 32'h9d2c_5680);
        y = y ^ ((y << 15) & 32'hefc6_0000);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== design/mtg_mul.sv =====
// Shared 32x32 multiplier, low word kept, result registered.
module mtg_mul (
    input  logic        aclk,
    input  logic [31:0] mul_a,
    input  logic [31:0] mul_b,
    output logic [31:0] prod_reg
);

    logic [63:0] full;

    assign full = 64'(mul_a) * 64'(mul_b);

    always_ff @(posedge aclk) begin
        prod_reg <= full[31:0];
    end

endmodule

// ===== design/mersenne_twister_generator_top.sv =====
// MT19937 generator: scalar seed, key seeding and tempered output words.
// Next beat: the word is read, registered, tempered and loaded into the output register;
// an output stall holds it and no new request is taken meanwhile. A twist of all 624 words
// in RAM comes first once they are used. Seeding writes the table word by word through the
// registered shared multiplier; key seeding adds two mixing passes and a last t[0] write.
// aresetn (sync, active low) clears control; the table is written before use.
module mersenne_twister_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_seed_value,
    input  logic        s_key_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_random_word
);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_SS_INIT = 5'd1;
    localparam logic [4:0] ST_SS_MUL  = 5'd2;
    localparam logic [4:0] ST_SS_WR   = 5'd3;
    localparam logic [4:0] ST_A1_MUL  = 5'd4;
    localparam logic [4:0] ST_A1_WR   = 5'd5;
    localparam logic [4:0] ST_A1_WRAP = 5'd6;
    localparam logic [4:0] ST_A2_MUL  = 5'd7;
    localparam logic [4:0] ST_A2_WR   = 5'd8;
    localparam logic [4:0] ST_A2_WRAP = 5'd9;
    localparam logic [4:0] ST_A_FIN   = 5'd10;
    localparam logic [4:0] ST_TW_INIT = 5'd11;
    localparam logic [4:0] ST_TW_CUR  = 5'd12;
    localparam logic [4:0] ST_TW_FAR  = 5'd13;
    localparam logic [4:0] ST_TW_WR   = 5'd14;
    localparam logic [4:0] ST_RD_ISS  = 5'd15;
    localparam logic [4:0] ST_RD_DAT  = 5'd16;
    localparam logic [4:0] ST_OUT     = 5'd17;

    localparam int AW = mtg_pkg::ADDR_W;

    // table RAM and key buffer
    logic [31:0] table_mem [mtg_pkg::STATE_WORDS];
    logic [31:0] key_mem   [mtg_pkg::KEY_DEPTH];

    logic [4:0]  state_reg;
    logic [AW-1:0] i_reg;          // working table index
    logic [AW-1:0] k_reg;          // remaining steps of a mixing pass
    logic [AW-1:0] read_index_reg;
    logic [mtg_pkg::KEY_AW-1:0]    j_reg;
    logic [mtg_pkg::KEY_CNT_W-1:0] key_count_reg;
    logic [mtg_pkg::KEY_CNT_W-1:0] key_len_reg;
    logic        seeded_reg;
    logic        arr_pend_reg;     // key seeding follows the scalar fill
    logic        next_pend_reg;    // a next beat waits on seeding/twist
    logic [31:0] p_reg;            // previous table word of the recurrence
    logic [31:0] cur_reg;
    logic [31:0] nx_reg;
    logic [31:0] rd_reg;
    logic [31:0] kd_reg;
    logic [31:0] tmp_reg;
    logic        m_valid_reg;
    logic [31:0] m_word_reg;

    logic [31:0] prod;
    logic [31:0] mix;
    logic [31:0] mul_b;
    logic [31:0] ss_val;
    logic [31:0] a1_val;
    logic [31:0] a2_val;
    logic [31:0] y;
    logic [31:0] tw_val;
    logic [AW-1:0] far_addr;
    logic [AW-1:0] i_inc;
    logic [AW-1:0] nx2_addr;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [31:0] wdata;
    logic        we;
    logic        s_fire;
    logic        key_room;
    logic [mtg_pkg::KEY_CNT_W-1:0] key_count_inc;
    logic [mtg_pkg::KEY_CNT_W-1:0] j_inc;
    logic [AW-1:0] k_max;

    assign s_ready       = (state_reg == ST_IDLE);
    assign s_fire        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_random_word = m_word_reg;

    assign mix = p_reg ^ (p_reg >> 30);

    always_comb begin
        case (state_reg)
            ST_SS_MUL: mul_b = mtg_pkg::SEED_MULT;
            ST_A1_MUL: mul_b = mtg_pkg::MIX1_MULT;
            default:   mul_b = mtg_pkg::MIX2_MULT;
        endcase
    end

    mtg_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mix),
        .mul_b    (mul_b),
        .prod_reg (prod)
    );

    assign ss_val = prod + 32'(i_reg);
    assign a1_val = (rd_reg ^ prod) + kd_reg + 32'(j_reg);
    assign a2_val = (rd_reg ^ prod) - 32'(i_reg);

    // twist of word i: cur = t[i], nx = t[i+1], rd = t[i+397]
    assign y      = (cur_reg & mtg_pkg::UPPER_BIT) | (nx_reg & mtg_pkg::LOWER_BITS);
    assign tw_val = rd_reg ^ (y >> 1) ^ (nx_reg[0] ? mtg_pkg::TWIST_MATRIX : 32'd0);

    assign far_addr = (i_reg >= (mtg_pkg::WORDS_CNT - mtg_pkg::OFFSET_CNT))
                    ? i_reg - (mtg_pkg::WORDS_CNT - mtg_pkg::OFFSET_CNT)
                    : i_reg + mtg_pkg::OFFSET_CNT;
    assign i_inc    = i_reg + AW'(1);
    assign nx2_addr = (i_inc == mtg_pkg::LAST_ADDR) ? '0 : i_inc + AW'(1);

    assign key_room      = (key_count_reg < mtg_pkg::KEY_CNT_W'(mtg_pkg::KEY_DEPTH));
    assign key_count_inc = key_room ? key_count_reg + mtg_pkg::KEY_CNT_W'(1) : key_count_reg;
    assign j_inc         = mtg_pkg::KEY_CNT_W'(j_reg) + mtg_pkg::KEY_CNT_W'(1);
    assign k_max = (AW'(key_len_reg) > mtg_pkg::WORDS_CNT) ? AW'(key_len_reg)
                                                            : mtg_pkg::WORDS_CNT;

    // RAM port control
    always_comb begin
        raddr = i_reg;
        we    = 1'b0;
        waddr = i_reg;
        wdata = ss_val;
        case (state_reg)
            ST_SS_INIT: begin
                we    = 1'b1;
                waddr = '0;
                wdata = p_reg;
            end
            ST_SS_WR: begin
                we = 1'b1;
            end
            ST_A1_WR: begin
                we    = 1'b1;
                wdata = a1_val;
            end
            ST_A2_WR: begin
                we    = 1'b1;
                wdata = a2_val;
            end
            ST_A1_WRAP, ST_A2_WRAP: begin
                we    = 1'b1;
                waddr = '0;
                wdata = p_reg;
            end
            ST_A_FIN: begin
                we    = 1'b1;
                waddr = '0;
                wdata = mtg_pkg::UPPER_BIT;
            end
            ST_TW_INIT: raddr = '0;
            ST_TW_CUR:  raddr = AW'(1);
            ST_TW_FAR:  raddr = far_addr;
            ST_TW_WR: begin
                we    = 1'b1;
                wdata = tw_val;
                raddr = nx2_addr;
            end
            ST_RD_ISS:  raddr = read_index_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            table_mem[waddr] <= wdata;
        end
        rd_reg <= table_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_req_type == mtg_pkg::REQ_KEY && key_room) begin
            key_mem[key_count_reg[mtg_pkg::KEY_AW-1:0]] <= s_seed_value;
        end
        kd_reg <= key_mem[j_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            read_index_reg <= mtg_pkg::WORDS_CNT;
            seeded_reg     <= 1'b0;
            key_count_reg  <= '0;
            arr_pend_reg   <= 1'b0;
            next_pend_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // ST_OUT reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (s_req_type)
                            mtg_pkg::REQ_SEED: begin
                                key_count_reg <= '0;
                                arr_pend_reg  <= 1'b0;
                                next_pend_reg <= 1'b0;
                                p_reg         <= s_seed_value;
                                state_reg     <= ST_SS_INIT;
                            end
                            mtg_pkg::REQ_KEY: begin
                                if (s_key_last) begin
                                    key_len_reg   <= key_count_inc;
                                    key_count_reg <= '0;
                                    arr_pend_reg  <= 1'b1;
                                    next_pend_reg <= 1'b0;
                                    p_reg         <= mtg_pkg::ARRAY_SEED;
                                    state_reg     <= ST_SS_INIT;
                                end else begin
                                    key_count_reg <= key_count_inc;
                                end
                            end
                            mtg_pkg::REQ_NEXT: begin
                                next_pend_reg <= 1'b1;
                                arr_pend_reg  <= 1'b0;
                                if (!seeded_reg) begin
                                    p_reg     <= '0;
                                    state_reg <= ST_SS_INIT;
                                end else if (read_index_reg >= mtg_pkg::WORDS_CNT) begin
                                    state_reg <= ST_TW_INIT;
                                end else begin
                                    state_reg <= ST_RD_ISS;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SS_INIT: begin
                    i_reg     <= AW'(1);
                    state_reg <= ST_SS_MUL;
                end
                ST_SS_MUL: state_reg <= ST_SS_WR;
                ST_SS_WR: begin
                    if (i_reg == mtg_pkg::LAST_ADDR) begin
                        seeded_reg     <= 1'b1;
                        read_index_reg <= mtg_pkg::WORDS_CNT;
                        if (arr_pend_reg) begin
                            // key mixing restarts from t[0]
                            p_reg     <= mtg_pkg::ARRAY_SEED;
                            i_reg     <= AW'(1);
                            j_reg     <= '0;
                            k_reg     <= k_max;
                            state_reg <= ST_A1_MUL;
                        end else if (next_pend_reg) begin
                            state_reg <= ST_TW_INIT;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        p_reg     <= ss_val;
                        i_reg     <= i_inc;
                        state_reg <= ST_SS_MUL;
                    end
                end
                ST_A1_MUL: state_reg <= ST_A1_WR;
                ST_A1_WR: begin
                    p_reg <= a1_val;
                    j_reg <= (j_inc >= key_len_reg) ? '0 : j_inc[mtg_pkg::KEY_AW-1:0];
                    if (i_reg == mtg_pkg::LAST_ADDR) begin
                        k_reg     <= k_reg - AW'(1);
                        i_reg     <= AW'(1);
                        state_reg <= ST_A1_WRAP;
                    end else begin
                        i_reg <= i_inc;
                        if (k_reg == AW'(1)) begin
                            k_reg     <= mtg_pkg::LAST_ADDR;
                            state_reg <= ST_A2_MUL;
                        end else begin
                            k_reg     <= k_reg - AW'(1);
                            state_reg <= ST_A1_MUL;
                        end
                    end
                end
                ST_A1_WRAP: begin
                    if (k_reg == '0) begin
                        k_reg     <= mtg_pkg::LAST_ADDR;
                        state_reg <= ST_A2_MUL;
                    end else begin
                        state_reg <= ST_A1_MUL;
                    end
                end
                ST_A2_MUL: state_reg <= ST_A2_WR;
                ST_A2_WR: begin
                    p_reg <= a2_val;
                    k_reg <= k_reg - AW'(1);
                    if (i_reg == mtg_pkg::LAST_ADDR) begin
                        i_reg     <= AW'(1);
                        state_reg <= ST_A2_WRAP;
                    end else begin
                        i_reg     <= i_inc;
                        state_reg <= (k_reg == AW'(1)) ? ST_A_FIN : ST_A2_MUL;
                    end
                end
                ST_A2_WRAP: state_reg <= (k_reg == '0) ? ST_A_FIN : ST_A2_MUL;
                ST_A_FIN: begin
                    arr_pend_reg   <= 1'b0;
                    seeded_reg     <= 1'b1;
                    read_index_reg <= mtg_pkg::WORDS_CNT;
                    state_reg      <= ST_IDLE;
                end
                ST_TW_INIT: begin
                    i_reg     <= '0;
                    state_reg <= ST_TW_CUR;
                end
                ST_TW_CUR: begin
                    cur_reg   <= rd_reg;
                    state_reg <= ST_TW_FAR;
                end
                ST_TW_FAR: begin
                    nx_reg    <= rd_reg;
                    state_reg <= ST_TW_WR;
                end
                ST_TW_WR: begin
                    cur_reg <= nx_reg;
                    if (i_reg == mtg_pkg::LAST_ADDR) begin
                        read_index_reg <= '0;
                        state_reg      <= ST_RD_ISS;
                    end else begin
                        i_reg     <= i_inc;
                        state_reg <= ST_TW_FAR;
                    end
                end
                ST_RD_ISS: state_reg <= ST_RD_DAT;
                ST_RD_DAT: begin
                    tmp_reg   <= mtg_pkg::temper(rd_reg);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_word_reg     <= tmp_reg;
                        read_index_reg <= read_index_reg + AW'(1);
                        next_pend_reg  <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
